// File: design/adcbcd_pkg.sv
// Shared types, constants and helper functions for the ADC averaging thermometer display.
`timescale 1ns / 1ps

package adcbcd_pkg;

  // Field widths of the input and result beats.
  localparam int SAMPLE_W = 10;
  localparam int READ_W   = 7;
  localparam int SEG_W    = 7;
  localparam int DIGIT_W  = 4;

  // Largest converter code.
  localparam int SAMPLE_MAX = (2 ** SAMPLE_W) - 1;

  // Item kinds carried in the mode field.
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  // Scaling (mean * 70 + 511) / 1023. The divide by 1023 is a multiply by
  // ceil(2^27 / 1023) followed by a 27-bit shift, exact for any scaled value.
  localparam int SCALED_W     = 17;
  localparam int SCALE_RND    = 511;
  localparam int RECIP_FS_W   = 18;
  localparam int RECIP_FS_SH  = 27;
  localparam logic [RECIP_FS_W-1:0] RECIP_FS = 18'd131201;

  // Digit enable codes: bit 1 is the tens digit, bit 0 the units digit.
  localparam logic [1:0] EN_OFF   = 2'b00;
  localparam logic [1:0] EN_UNITS = 2'b01;
  localparam logic [1:0] EN_TENS  = 2'b10;

  // Input beat.
  typedef struct packed {
    logic                mode;
    logic [SAMPLE_W-1:0] sample;
  } in_t;

  // Result beat.
  typedef struct packed {
    logic [SEG_W-1:0]  segments;
    logic              high_digit_on;
    logic              low_digit_on;
    logic [READ_W-1:0] reading;
    logic              new_reading;
  } out_t;

  // Tens digit of a 7-bit value: floor(r * 205 / 2048) is exact below 1029.
  function automatic logic [DIGIT_W-1:0] tens_of(input logic [READ_W-1:0] r);
    logic [14:0] prod;
    prod = 15'(r) * 15'd205;
    return prod[14:11];
  endfunction

  // Units digit of a 7-bit value.
  function automatic logic [DIGIT_W-1:0] units_of(input logic [READ_W-1:0] r);
    logic [READ_W-1:0] tens_x10;
    logic [READ_W-1:0] rem;
    tens_x10 = READ_W'(tens_of(r)) * READ_W'(10);
    rem      = r - tens_x10;
    return rem[DIGIT_W-1:0];
  endfunction

  // Seven-segment pattern of a decimal digit; codes above nine are blank.
  function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] seg;
    case (d)
      4'd0:    seg = 7'h77;
      4'd1:    seg = 7'h41;
      4'd2:    seg = 7'h3B;
      4'd3:    seg = 7'h6B;
      4'd4:    seg = 7'h4D;
      4'd5:    seg = 7'h6E;
      4'd6:    seg = 7'h7E;
      4'd7:    seg = 7'h43;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h4F;
      default: seg = '0;
    endcase
    return seg;
  endfunction

endpackage

// File: design/adc_average_bcd_two_digit_display_top.sv
// Top level: sample averaging, scaling to degrees and two-digit multiplexed display drive.
// Path of an input beat to its result beat: accumulate register, mean and scale
// register, result register; an output stall holds the beat where it is.
// Throughput: one item per cycle while out_ready is high; the three in-order stages
// each refill as soon as the one after it moves, so stalls leave no bubbles.
// Reset (synchronous, rst_n low) clears the running sum, the sample count, the
// stored reading, the digit select, the segment latch and both digit enables.
`timescale 1ns / 1ps

module adc_average_bcd_two_digit_display_top #(
  parameter int SAMPLES_PER_READING = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  adcbcd_pkg::in_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output adcbcd_pkg::out_t  out_data
);

  // Sum of a full set of samples and the sample counter.
  localparam int SUM_W = $clog2(SAMPLES_PER_READING * adcbcd_pkg::SAMPLE_MAX + 1);
  localparam int CNT_W = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(SAMPLES_PER_READING - 1);

  // Truncated mean as a multiply by ceil(2^k / N) and a k-bit shift. With
  // k = SUM_W + ceil(log2 N) the error term stays below one for every sum.
  localparam int RECIP_SH = SUM_W + $clog2(SAMPLES_PER_READING);
  localparam int RECIP_W  = SUM_W + 1;
  localparam longint unsigned RECIP_VAL =
    ((64'd1 << RECIP_SH) + SAMPLES_PER_READING - 1) / SAMPLES_PER_READING;
  localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'(RECIP_VAL);
  localparam int MEAN_PROD_W = SUM_W + RECIP_W;
  localparam int FS_PROD_W   = adcbcd_pkg::SCALED_W + adcbcd_pkg::RECIP_FS_W;

  // Accumulator state.
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] sum_add;
  logic             last_sample;

  // Stage 1: item kind and the completed sum.
  logic             s1_valid_r;
  logic             s1_tick_r;
  logic             s1_done_r;
  logic [SUM_W-1:0] s1_sum_r;

  // Stage 2: item kind and the scaled value awaiting the divide by 1023.
  logic                               s2_valid_r;
  logic                               s2_tick_r;
  logic                               s2_done_r;
  logic [adcbcd_pkg::SCALED_W-1:0]    s2_scaled_r;

  // Display state, updated in item order at the result register.
  logic [adcbcd_pkg::READ_W-1:0] reading_r, reading_nxt;
  logic                          tens_next_r, tens_next_nxt;
  logic [adcbcd_pkg::SEG_W-1:0]  seg_r, seg_nxt;
  logic [1:0]                    en_r, en_nxt;

  // Result register.
  logic             out_valid_r;
  adcbcd_pkg::out_t out_data_r, out_data_nxt;

  // Handshake chain: a stage loads when it is empty or its content moves on.
  logic out_load_ok;
  logic s2_load_ok;
  logic s1_load_ok;
  logic in_fire;
  logic s1_fire;
  logic s2_fire;

  assign out_load_ok = !out_valid_r || out_ready;
  assign s2_load_ok  = !s2_valid_r || out_load_ok;
  assign s1_load_ok  = !s1_valid_r || s2_load_ok;
  assign in_ready    = s1_load_ok;
  assign in_fire     = in_valid && in_ready;
  assign s1_fire     = s1_valid_r && s2_load_ok;
  assign s2_fire     = s2_valid_r && out_load_ok;

  // Accumulate samples; the last of a set restarts the sum.
  assign sum_add     = sum_r + SUM_W'(in_data.sample);
  assign last_sample = (cnt_r == LAST_IDX);

  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (in_fire && (in_data.mode == adcbcd_pkg::MODE_SAMPLE)) begin
      if (last_sample) begin
        sum_nxt = '0;
        cnt_nxt = '0;
      end else begin
        sum_nxt = sum_add;
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Stage 1 register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load_ok) begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_tick_r <= (in_data.mode == adcbcd_pkg::MODE_TICK);
      s1_done_r <= (in_data.mode == adcbcd_pkg::MODE_SAMPLE) && last_sample;
      s1_sum_r  <= sum_add;
    end
  end

  // Mean of the set, then mean * 70 + 511 as shifts and adds.
  logic [MEAN_PROD_W-1:0]          mean_prod;
  logic [adcbcd_pkg::SAMPLE_W-1:0] mean;
  logic [adcbcd_pkg::SCALED_W-1:0] mean_ext;
  logic [adcbcd_pkg::SCALED_W-1:0] scaled;

  assign mean_prod = MEAN_PROD_W'(s1_sum_r) * MEAN_PROD_W'(RECIP_MUL);
  assign mean      = mean_prod[RECIP_SH +: adcbcd_pkg::SAMPLE_W];
  assign mean_ext  = adcbcd_pkg::SCALED_W'(mean);
  assign scaled    = (mean_ext << 6) + (mean_ext << 2) + (mean_ext << 1)
                   + adcbcd_pkg::SCALED_W'(adcbcd_pkg::SCALE_RND);

  // Stage 2 register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_load_ok) begin
      s2_valid_r <= s1_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s2_tick_r   <= s1_tick_r;
      s2_done_r   <= s1_done_r;
      s2_scaled_r <= scaled;
    end
  end

  // Divide by 1023 through the reciprocal multiply.
  logic [FS_PROD_W-1:0]          fs_prod;
  logic [adcbcd_pkg::READ_W-1:0] new_reading_val;

  assign fs_prod         = FS_PROD_W'(s2_scaled_r) * FS_PROD_W'(adcbcd_pkg::RECIP_FS);
  assign new_reading_val = fs_prod[adcbcd_pkg::RECIP_FS_SH +: adcbcd_pkg::READ_W];

  // Digit split of the stored reading for a refresh tick.
  logic [adcbcd_pkg::DIGIT_W-1:0] tens_digit;
  logic [adcbcd_pkg::DIGIT_W-1:0] units_digit;

  assign tens_digit  = adcbcd_pkg::tens_of(reading_r);
  assign units_digit = adcbcd_pkg::units_of(reading_r);

  // Next display state and the result beat it produces.
  always_comb begin
    reading_nxt   = reading_r;
    tens_next_nxt = tens_next_r;
    seg_nxt       = seg_r;
    en_nxt        = en_r;
    if (s2_fire) begin
      if (s2_tick_r) begin
        if (tens_next_r) begin
          seg_nxt = adcbcd_pkg::seg_of(tens_digit);
          en_nxt  = adcbcd_pkg::EN_TENS;
        end else begin
          seg_nxt = adcbcd_pkg::seg_of(units_digit);
          en_nxt  = adcbcd_pkg::EN_UNITS;
        end
        tens_next_nxt = !tens_next_r;
      end else if (s2_done_r) begin
        reading_nxt = new_reading_val;
      end
    end
    out_data_nxt.segments      = seg_nxt;
    out_data_nxt.high_digit_on = en_nxt[1];
    out_data_nxt.low_digit_on  = en_nxt[0];
    out_data_nxt.reading       = reading_nxt;
    out_data_nxt.new_reading   = !s2_tick_r && s2_done_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reading_r   <= '0;
      tens_next_r <= 1'b0;
      seg_r       <= '0;
      en_r        <= adcbcd_pkg::EN_OFF;
    end else begin
      reading_r   <= reading_nxt;
      tens_next_r <= tens_next_nxt;
      seg_r       <= seg_nxt;
      en_r        <= en_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load_ok) begin
      out_valid_r <= s2_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The sample counter never passes the end of a set.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LAST_IDX)
    else $error("sample counter beyond the end of a set");

  // A finished average always lands in the 0..70 degree range.
  a_reading_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.new_reading) |-> (out_data_r.reading <= 7'd70))
    else $error("scaled reading out of range");

  // At most one digit is enabled at a time.
  a_enable_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(en_r))
    else $error("both digit enables high");

  // A refresh tick always switches the digit select and enables a digit.
  a_tick_toggles: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_fire && s2_tick_r) |=>
      ((tens_next_r != $past(tens_next_r)) && (en_r != adcbcd_pkg::EN_OFF)))
    else $error("refresh tick did not switch digits");

endmodule

// File: bench/adc_average_bcd_two_digit_display_top_tb.sv
// Testbench for the averaging thermometer display: directed table, random beats, scoreboard.
`timescale 1ns / 1ps

module adc_average_bcd_two_digit_display_top_tb;

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 12;
  localparam int AVG_LEN         = 8;
  localparam int RANDOM_ITEMS    = 1130;
  localparam int PAUSE_AT        = 700;
  localparam int HOLD_OFF_AT     = 400;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int IDLE_LIMIT      = 2000;
  localparam int DRAIN_CYCLES    = 10;
  localparam int SCALE_TOP       = 70;
  localparam int ROUND_ADD       = 511;
  localparam int FULL_SCALE      = 1023;

  // Segment patterns for the digits zero through nine.
  localparam logic [adcbcd_pkg::SEG_W-1:0] DIGIT_SEGS [10] = '{
    7'h77, 7'h41, 7'h3B, 7'h6B, 7'h4D, 7'h6E, 7'h7E, 7'h43, 7'h7F, 7'h4F
  };

  // Receiver stall patterns.
  typedef enum int {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_MOSTLY} ready_style_t;

  // One row of the directed table; pinned rows carry a hand-written result.
  typedef struct {
    adcbcd_pkg::in_t  beat;
    bit               pinned;
    adcbcd_pkg::out_t result;
  } table_row_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             out_ready = 1'b0;
  adcbcd_pkg::in_t  in_data   = '0;
  logic             in_ready;
  logic             out_valid;
  adcbcd_pkg::out_t out_data;

  // Side information that travels with the beat on offer.
  bit               row_pinned = 1'b0;
  adcbcd_pkg::out_t row_result = '0;

  // Predicted display state, cleared as reset leaves it.
  logic [12:0]                   acc_sum       = '0;
  int unsigned                   acc_count     = 0;
  logic [adcbcd_pkg::READ_W-1:0] shown_reading = '0;
  logic                          tens_turn     = 1'b0;
  logic [adcbcd_pkg::SEG_W-1:0]  lit_segments  = '0;
  logic [1:0]                    lit_digits    = adcbcd_pkg::EN_OFF;

  adcbcd_pkg::out_t expected_display[$];
  table_row_t       directed_rows[$];
  int               in_count    = 0;
  int               idle_cycles = 0;
  int               fail_count  = 0;

  // Stimulus generator state for well-formed averaging groups.
  int group_base = 0;
  int group_left = 0;

  adc_average_bcd_two_digit_display_top #(
    .SAMPLES_PER_READING(AVG_LEN)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b1;
    #CLK_HALF;
    clk = 1'b0;
    #CLK_HALF;
  end

  // Advance the predicted display by one beat and return what it drives.
  function automatic adcbcd_pkg::out_t display_after(input adcbcd_pkg::in_t beat);
    int unsigned      mean;
    int unsigned      degrees;
    adcbcd_pkg::out_t res;
    res.new_reading = 1'b0;
    if (beat.mode == adcbcd_pkg::MODE_SAMPLE) begin
      acc_sum   = acc_sum + 13'(beat.sample);
      acc_count = acc_count + 1;
      if (acc_count == AVG_LEN) begin
        mean            = acc_sum / AVG_LEN;
        degrees         = (mean * SCALE_TOP + ROUND_ADD) / FULL_SCALE;
        shown_reading   = adcbcd_pkg::READ_W'(degrees);
        acc_sum         = '0;
        acc_count       = 0;
        res.new_reading = 1'b1;
      end
    end else begin
      if (tens_turn) begin
        lit_segments = DIGIT_SEGS[shown_reading / 10];
        lit_digits   = adcbcd_pkg::EN_TENS;
      end else begin
        lit_segments = DIGIT_SEGS[shown_reading % 10];
        lit_digits   = adcbcd_pkg::EN_UNITS;
      end
      tens_turn = ~tens_turn;
    end
    res.segments      = lit_segments;
    res.high_digit_on = lit_digits[1];
    res.low_digit_on  = lit_digits[0];
    res.reading       = shown_reading;
    return res;
  endfunction

  // Compare one result beat against the oldest expectation.
  task automatic check_display(input adcbcd_pkg::out_t got);
    adcbcd_pkg::out_t want;
    if (expected_display.size() == 0) begin
      $error("unexpected result beat %h with nothing expected", got);
      fail_count++;
    end else begin
      want = expected_display.pop_front();
      if (got.segments !== want.segments) begin
        $error("segments: expected %h, got %h", want.segments, got.segments);
        fail_count++;
      end
      if (got.high_digit_on !== want.high_digit_on) begin
        $error("high_digit_on: expected %b, got %b", want.high_digit_on, got.high_digit_on);
        fail_count++;
      end
      if (got.low_digit_on !== want.low_digit_on) begin
        $error("low_digit_on: expected %b, got %b", want.low_digit_on, got.low_digit_on);
        fail_count++;
      end
      if (got.reading !== want.reading) begin
        $error("reading: expected %0d, got %0d", want.reading, got.reading);
        fail_count++;
      end
      if (got.new_reading !== want.new_reading) begin
        $error("new_reading: expected %b, got %b", want.new_reading, got.new_reading);
        fail_count++;
      end
    end
  endtask

  // Track accepted beats on both channels at the rising edge.
  always @(posedge clk) begin
    adcbcd_pkg::out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        want = display_after(in_data);
        if (row_pinned) begin
          want = row_result;
        end
        expected_display.push_back(want);
        in_count <= in_count + 1;
      end
      if (out_valid && out_ready) begin
        check_display(out_data);
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog on cycles without any accepted beat.
  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: changing stall patterns, plus one long hold-off once traffic is flowing.
  initial begin
    ready_style_t style;
    int           span;
    bit           held;
    held = 1'b0;
    forever begin
      style = ready_style_t'($urandom_range(0, 3));
      span  = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk);
        case (style)
          READY_ALWAYS: out_ready <= 1'b1;
          READY_HALF:   out_ready <= 1'($urandom_range(0, 1));
          READY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:      out_ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
      if (!held && in_count >= HOLD_OFF_AT) begin
        held = 1'b1;
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end
    end
  end

  task automatic add_row(input logic mode, input logic [adcbcd_pkg::SAMPLE_W-1:0] sample,
                         input bit pinned, input adcbcd_pkg::out_t result);
    table_row_t row;
    row.beat.mode   = mode;
    row.beat.sample = sample;
    row.pinned      = pinned;
    row.result      = result;
    directed_rows.push_back(row);
  endtask

  // Offer one beat from the falling edge and hold it until accepted.
  task automatic send_beat(input adcbcd_pkg::in_t beat, input bit pinned,
                           input adcbcd_pkg::out_t result);
    @(negedge clk);
    in_valid   <= 1'b1;
    in_data    <= beat;
    row_pinned <= pinned;
    row_result <= result;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid for a gap of the given number of cycles.
  task automatic rest(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      in_valid   <= 1'b0;
      row_pinned <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    rest(1);
    while (expected_display.size() != 0) @(posedge clk);
  endtask

  // Samples cluster around a per-group level so readings spread over 0..70.
  function automatic logic [adcbcd_pkg::SAMPLE_W-1:0] next_sample();
    int pick;
    if (group_left == 0) begin
      pick = $urandom_range(0, 7);
      if (pick == 0) begin
        group_base = 0;
      end else if (pick == 1) begin
        group_base = adcbcd_pkg::SAMPLE_MAX;
      end else begin
        group_base = $urandom_range(0, adcbcd_pkg::SAMPLE_MAX);
      end
      group_left = AVG_LEN;
    end
    group_left = group_left - 1;
    if ($urandom_range(0, 9) == 0) begin
      return adcbcd_pkg::SAMPLE_W'($urandom_range(0, adcbcd_pkg::SAMPLE_MAX));
    end
    pick = group_base + $urandom_range(0, 16) - 8;
    if (pick < 0) begin
      pick = 0;
    end else if (pick > adcbcd_pkg::SAMPLE_MAX) begin
      pick = adcbcd_pkg::SAMPLE_MAX;
    end
    return adcbcd_pkg::SAMPLE_W'(pick);
  endfunction

  // Main stimulus: reset, directed table, random bursts, drain and verdict.
  initial begin
    adcbcd_pkg::in_t beat;
    int              sent;
    int              burst;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Ticks right after reset show a zero reading, units first.
    add_row(adcbcd_pkg::MODE_TICK, '0, 1'b1,
            adcbcd_pkg::out_t'{7'h77, 1'b0, 1'b1, 7'd0, 1'b0});
    add_row(adcbcd_pkg::MODE_TICK, '0, 1'b1,
            adcbcd_pkg::out_t'{7'h77, 1'b1, 1'b0, 7'd0, 1'b0});
    // Eight full-scale samples: display holds, then the reading jumps to 70.
    for (int i = 0; i < AVG_LEN - 1; i++) begin
      add_row(adcbcd_pkg::MODE_SAMPLE, adcbcd_pkg::SAMPLE_W'(adcbcd_pkg::SAMPLE_MAX),
              1'b0, '0);
    end
    add_row(adcbcd_pkg::MODE_SAMPLE, adcbcd_pkg::SAMPLE_W'(adcbcd_pkg::SAMPLE_MAX), 1'b1,
            adcbcd_pkg::out_t'{7'h77, 1'b1, 1'b0, 7'd70, 1'b1});
    add_row(adcbcd_pkg::MODE_TICK, '0, 1'b1,
            adcbcd_pkg::out_t'{7'h77, 1'b0, 1'b1, 7'd70, 1'b0});
    add_row(adcbcd_pkg::MODE_TICK, '0, 1'b1,
            adcbcd_pkg::out_t'{7'h43, 1'b1, 1'b0, 7'd70, 1'b0});
    // A tick ignores whatever sits in the sample field.
    add_row(adcbcd_pkg::MODE_TICK, adcbcd_pkg::SAMPLE_W'(adcbcd_pkg::SAMPLE_MAX), 1'b1,
            adcbcd_pkg::out_t'{7'h77, 1'b0, 1'b1, 7'd70, 1'b0});
    // Eight zero samples bring the reading back to zero.
    for (int i = 0; i < AVG_LEN - 1; i++) begin
      add_row(adcbcd_pkg::MODE_SAMPLE, '0, 1'b0, '0);
    end
    add_row(adcbcd_pkg::MODE_SAMPLE, '0, 1'b1,
            adcbcd_pkg::out_t'{7'h77, 1'b0, 1'b1, 7'd0, 1'b1});
    add_row(adcbcd_pkg::MODE_TICK, '0, 1'b1,
            adcbcd_pkg::out_t'{7'h77, 1'b1, 1'b0, 7'd0, 1'b0});

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].beat, directed_rows[i].pinned, directed_rows[i].result);
      if ($urandom_range(0, 2) == 0) begin
        rest($urandom_range(1, 3));
      end
    end
    wait_drained();

    // Random bursts of samples and ticks.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        if (sent == PAUSE_AT) begin
          wait_drained();
        end
        if ($urandom_range(0, 4) < 3) begin
          beat.mode   = adcbcd_pkg::MODE_SAMPLE;
          beat.sample = next_sample();
        end else begin
          beat.mode   = adcbcd_pkg::MODE_TICK;
          beat.sample = adcbcd_pkg::SAMPLE_W'($urandom_range(0, adcbcd_pkg::SAMPLE_MAX));
        end
        send_beat(beat, 1'b0, '0);
        sent++;
      end
      rest(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10));
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
